// ----- rtl/jkv_pkg.sv -----
// ----------------------------------------------------------------------------
// jkv_pkg
// Shared types and constants for the streaming JSON key/value extractor:
// character codes, parser state record and per-beat result record.
// ----------------------------------------------------------------------------
package jkv_pkg;

    localparam int KEY_BYTES_DEF = 32;
    localparam int VALUE_MAX_DEF = 256;

    localparam int KEY_WORDS    = 4;
    localparam int KEY_WORD_W   = 64;
    localparam int KEY_VEC_W    = KEY_WORDS * KEY_WORD_W;
    localparam int KEY_POS_W    = 5;
    localparam int VAL_POS_W    = 8;
    localparam int CAP_W        = 9;
    localparam int CFG_INDEX_W  = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_CAP  = 3'd5;

    // character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef struct packed {
        logic                 inside_string;
        logic                 escape_pending;
        logic                 in_key;
        logic                 in_value;
        logic                 key_matched;
        logic                 key_compare_ok;
        logic [KEY_POS_W-1:0] key_position;
        logic [VAL_POS_W-1:0] value_position;
        logic                 skipping_space;
        logic                 search_finished;
    } parser_state_t;

    localparam parser_state_t PARSER_CLEAR = '{
        inside_string:   1'b0,
        escape_pending:  1'b0,
        in_key:          1'b0,
        in_value:        1'b0,
        key_matched:     1'b0,
        key_compare_ok:  1'b1,
        key_position:    '0,
        value_position:  '0,
        skipping_space:  1'b0,
        search_finished: 1'b0
    };

    typedef struct packed {
        logic                 present;
        logic [7:0]           value_byte;
        logic                 value_valid;
        logic                 done_res;
        logic                 found;
        logic [VAL_POS_W-1:0] value_length;
    } step_result_t;

endpackage

// ----- rtl/jkv_step.sv -----
// ----------------------------------------------------------------------------
// jkv_step
// One parser step: next parser state and result for one document byte.
// ----------------------------------------------------------------------------
module jkv_step #(
    parameter int KEY_BYTES = jkv_pkg::KEY_BYTES_DEF
) (
    input  jkv_pkg::parser_state_t                 state,
    input  logic [7:0]                             text_byte,
    input  logic                                   first_byte,
    input  logic                                   last_byte,
    input  logic [jkv_pkg::KEY_VEC_W-1:0]          key_vec,
    input  logic [jkv_pkg::KEY_POS_W-1:0]          key_length,
    input  logic [jkv_pkg::CAP_W-1:0]              value_limit,
    output jkv_pkg::parser_state_t                 state_next,
    output jkv_pkg::step_result_t                  result
);
    import jkv_pkg::*;

    localparam logic [KEY_POS_W-1:0] KEY_LIMIT = KEY_POS_W'(KEY_BYTES - 1);

    parser_state_t n;
    logic          stop;
    logic          take_key;
    logic          take_val;
    logic          fin;
    logic          vld;
    logic          done;
    logic          fnd;
    logic [7:0]    tbyte;

    always_comb
    begin
        n        = state;
        stop     = 1'b0;
        take_key = 1'b0;
        take_val = 1'b0;
        fin      = 1'b0;
        vld      = 1'b0;
        done     = 1'b0;
        fnd      = 1'b0;
        tbyte    = 8'h00;

        if (first_byte)
        begin
            n = PARSER_CLEAR;
        end

        if (!n.search_finished)
        begin
            // whitespace skip after a matching key's colon
            if (n.skipping_space)
            begin
                if (text_byte == CH_SPACE || text_byte == CH_LF || text_byte == CH_CR)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    n.skipping_space = 1'b0;
                    n.in_value       = 1'b1;
                    n.value_position = '0;
                    if (text_byte == CH_QUOTE)
                    begin
                        n.inside_string = 1'b1;
                        stop            = 1'b1;
                    end
                end
            end

            if (!stop)
            begin
                priority if (n.escape_pending)
                begin
                    n.escape_pending = 1'b0;
                    take_key = n.in_key;
                    take_val = !n.in_key && n.in_value;
                end
                else if (text_byte == CH_BACKSLASH)
                begin
                    n.escape_pending = 1'b1;
                end
                else if (text_byte == CH_QUOTE)
                begin
                    n.inside_string = !n.inside_string;
                    if (n.inside_string)
                    begin
                        if (!n.in_key && !n.in_value)
                        begin
                            n.in_key         = 1'b1;
                            n.key_position   = '0;
                            n.key_compare_ok = 1'b1;
                        end
                    end
                    else if (n.in_key)
                    begin
                        n.in_key = 1'b0;
                        if (n.key_compare_ok && n.key_position == key_length)
                        begin
                            n.key_matched = 1'b1;
                        end
                    end
                    else if (n.in_value)
                    begin
                        n.in_value = 1'b0;
                        fin = n.key_matched;
                    end
                end
                else if (n.inside_string)
                begin
                    take_key = n.in_key;
                    take_val = !n.in_key && n.in_value;
                end
                else if (text_byte == CH_COLON && n.key_matched && !n.in_value)
                begin
                    n.skipping_space = 1'b1;
                end
                else if (n.in_value)
                begin
                    if (text_byte == CH_COMMA || text_byte == CH_RBRACE
                        || text_byte == CH_RBRACKET)
                    begin
                        n.in_value = 1'b0;
                        fin = n.key_matched;
                    end
                    else
                    begin
                        take_val = 1'b1;
                    end
                end
                else
                begin
                    // bytes outside strings and values leave the state alone
                    stop = 1'b0;
                end
            end

            // key byte: compare against target, truncate long keys
            if (take_key && n.key_position < KEY_LIMIT)
            begin
                tbyte = key_vec[{n.key_position, 3'b000} +: 8];
                if (n.key_position >= key_length || tbyte != text_byte)
                begin
                    n.key_compare_ok = 1'b0;
                end
                n.key_position = n.key_position + 1'b1;
            end

            // value byte: emit while under the limit of capacity minus one
            if (take_val && {1'b0, n.value_position} < value_limit)
            begin
                vld              = 1'b1;
                n.value_position = n.value_position + 1'b1;
            end

            if (fin)
            begin
                n.search_finished = 1'b1;
                done              = 1'b1;
                fnd               = n.key_matched;
            end

            if (!n.search_finished && last_byte)
            begin
                n.search_finished = 1'b1;
                done              = 1'b1;
                fnd               = n.key_matched;
            end
        end
    end

    assign state_next          = n;
    assign result.present      = vld || done;
    assign result.value_byte   = vld ? text_byte : 8'h00;
    assign result.value_valid  = vld;
    assign result.done_res     = done;
    assign result.found        = done && fnd;
    assign result.value_length = n.value_position;

endmodule

// ----- rtl/json_key_value_extractor_top.sv -----
// ----------------------------------------------------------------------------
// json_key_value_extractor_top
// Streaming JSON key/value extractor: scans a document byte by byte and
// returns the bytes of the value that belongs to a configured key.
// ----------------------------------------------------------------------------
// Feed the document one byte per text beat, first_byte set on the opening
// byte and last_byte on the closing one. The parser state is a handful of
// flags and two counters, updated by one short step in the cycle the beat
// is taken, so a byte can be accepted in every cycle that the output
// register can take a result. A beat yields at most one result beat, in the
// next cycle, carrying a captured value byte, the done/found report, or
// both; bytes that produce nothing (keys, punctuation, whitespace, anything
// after the search is over) yield no result beat. The result sits in an
// output register, and a new text beat is taken while that register is free
// or being drained in the same cycle. Key bytes are compared as they arrive,
// keys are cut at KEY_BYTES-1 bytes, and at most capacity minus one value
// bytes come out. Configuration writes take effect at once and must only be
// issued while no text beat is outstanding.
module json_key_value_extractor_top #(
    parameter int KEY_BYTES = jkv_pkg::KEY_BYTES_DEF,
    parameter int VALUE_MAX = jkv_pkg::VALUE_MAX_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // configuration write port
    input  logic                                   cfg_we,
    input  logic [jkv_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [jkv_pkg::KEY_WORD_W-1:0]         cfg_data,

    // document byte channel
    input  logic                                   text_valid,
    output logic                                   text_ready,
    input  logic [7:0]                             text_byte,
    input  logic                                   first_byte,
    input  logic                                   last_byte,

    // result channel
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic [7:0]                             value_byte,
    output logic                                   value_valid,
    output logic                                   done_res,
    output logic                                   found,
    output logic [jkv_pkg::VAL_POS_W-1:0]          value_length
);
    import jkv_pkg::*;

    localparam logic [CAP_W-1:0] VMAX      = CAP_W'(VALUE_MAX);
    localparam logic [CAP_W-1:0] LIMIT_RST = CAP_W'(VALUE_MAX - 1);

    // configuration registers
    logic [KEY_VEC_W-1:0] key_vec_reg;
    logic [KEY_POS_W-1:0] key_length_reg;
    logic [CAP_W-1:0]     value_limit_reg;   // capacity minus one, clamped
    logic [CAP_W-1:0]     cap_clamped;

    // parser state and output register
    parser_state_t        state_reg;
    parser_state_t        state_next;
    step_result_t         step_res;
    logic                 result_valid_reg;
    logic [7:0]           value_byte_reg;
    logic                 value_valid_reg;
    logic                 done_res_reg;
    logic                 found_reg;
    logic [VAL_POS_W-1:0] value_length_reg;

    logic                 text_beat;

    // capacity of zero behaves as one, above the buffer size as the buffer size
    always_comb
    begin
        priority if (cfg_data[CAP_W-1:0] == '0)
        begin
            cap_clamped = CAP_W'(1);
        end
        else if (cfg_data[CAP_W-1:0] > VMAX)
        begin
            cap_clamped = VMAX;
        end
        else
        begin
            cap_clamped = cfg_data[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vec_reg     <= '0;
            key_length_reg  <= '0;
            value_limit_reg <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_WORD_0: key_vec_reg[0*KEY_WORD_W +: KEY_WORD_W] <= cfg_data;
                REG_KEY_WORD_1: key_vec_reg[1*KEY_WORD_W +: KEY_WORD_W] <= cfg_data;
                REG_KEY_WORD_2: key_vec_reg[2*KEY_WORD_W +: KEY_WORD_W] <= cfg_data;
                REG_KEY_WORD_3: key_vec_reg[3*KEY_WORD_W +: KEY_WORD_W] <= cfg_data;
                REG_KEY_LENGTH: key_length_reg  <= cfg_data[KEY_POS_W-1:0];
                REG_VALUE_CAP:  value_limit_reg <= cap_clamped - 1'b1;
                default:        ;   // unused indexes are ignored
            endcase
        end
    end

    // one parser step per accepted beat
    jkv_step #(
        .KEY_BYTES (KEY_BYTES)
    ) u_step (
        .state       (state_reg),
        .text_byte   (text_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .key_vec     (key_vec_reg),
        .key_length  (key_length_reg),
        .value_limit (value_limit_reg),
        .state_next  (state_next),
        .result      (step_res)
    );

    // output register is free, or drained this cycle
    assign text_ready = !result_valid_reg || result_ready;
    assign text_beat  = text_valid && text_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= PARSER_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (text_beat)
            begin
                state_reg <= state_next;
            end
            if (text_beat && step_res.present)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (text_beat && step_res.present)
        begin
            value_byte_reg   <= step_res.value_byte;
            value_valid_reg  <= step_res.value_valid;
            done_res_reg     <= step_res.done_res;
            found_reg        <= step_res.found;
            value_length_reg <= step_res.value_length;
        end
    end

    assign result_valid = result_valid_reg;
    assign value_byte   = value_byte_reg;
    assign value_valid  = value_valid_reg;
    assign done_res     = done_res_reg;
    assign found        = found_reg;
    assign value_length = value_length_reg;

    // a finished search stays finished until a new document starts
    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.search_finished && !(text_beat && first_byte))
            |=> state_reg.search_finished)
        else $error("search_finished dropped without a new document");

    // every result beat carries a value byte or the done report
    a_result_content: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (value_valid || done_res))
        else $error("empty result beat");

    // found is only ever reported together with done
    a_found_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && found) |-> done_res)
        else $error("found without done");

    // whitespace skip and a pending escape never coexist
    a_skip_escape: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.skipping_space && state_reg.escape_pending))
        else $error("escape pending during whitespace skip");

    // a beat that reports done leaves the parser finished
    a_done_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (text_beat && step_res.done_res) |=> state_reg.search_finished)
        else $error("done reported but parser not finished");

endmodule

// ----- tb/jkv_value_checker.sv -----
// ----------------------------------------------------------------------------
// jkv_value_checker
// Watches the configuration port and both beat channels of the JSON key/value
// extractor, predicts the result beat of every accepted text beat and
// compares the accepted result beats against those predictions in order.
// ----------------------------------------------------------------------------
module jkv_value_checker #(
    parameter int KEY_BYTES = jkv_pkg::KEY_BYTES_DEF,
    parameter int VALUE_MAX = jkv_pkg::VALUE_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [jkv_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [jkv_pkg::KEY_WORD_W-1:0]    cfg_data,
    input  logic                              text_valid,
    input  logic                              text_ready,
    input  logic [7:0]                        text_byte,
    input  logic                              first_byte,
    input  logic                              last_byte,
    input  logic                              result_valid,
    input  logic                              result_ready,
    input  logic [7:0]                        value_byte,
    input  logic                              value_valid,
    input  logic                              done_res,
    input  logic                              found,
    input  logic [jkv_pkg::VAL_POS_W-1:0]     value_length,
    output int                                mismatch_count,
    output int                                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import jkv_pkg::*;

    parser_state_t          ps;
    logic [KEY_WORD_W-1:0]  key_word [KEY_WORDS];
    logic [KEY_POS_W-1:0]   key_len;
    logic [CAP_W-1:0]       cap_reg;
    step_result_t           beat;
    step_result_t           pending_values [$];
    int                     errors;

    // key bytes beyond KEY_BYTES-1 are dropped
    function void take_key(input logic [7:0] c);
        logic [7:0] tgt;
        tgt = key_word[ps.key_position[4:3]][ps.key_position[2:0]*8 +: 8];
        if (int'(ps.key_position) < KEY_BYTES - 1) begin
            if (ps.key_position >= key_len || tgt != c)
                ps.key_compare_ok = 1'b0;
            ps.key_position = ps.key_position + 1'b1;
        end
    endfunction

    // capacity 0 behaves as 1, anything above VALUE_MAX as VALUE_MAX
    function void take_value(input logic [7:0] c);
        int lim;
        lim = int'(cap_reg);
        if (lim == 0)
            lim = 1;
        if (lim > VALUE_MAX)
            lim = VALUE_MAX;
        if (int'(ps.value_position) < lim - 1) begin
            beat.value_valid = 1'b1;
            beat.value_byte = c;
            ps.value_position = ps.value_position + 1'b1;
        end
    endfunction

    function void finish_search();
        ps.search_finished = 1'b1;
        beat.done_res = 1'b1;
        beat.found = ps.key_matched;
    endfunction

    function void scan_byte(input logic [7:0] c);
        if (ps.skipping_space) begin
            if (c == CH_SPACE || c == CH_LF || c == CH_CR)
                return;
            ps.skipping_space = 1'b0;
            ps.in_value = 1'b1;
            ps.value_position = '0;
            if (c == CH_QUOTE) begin
                ps.inside_string = 1'b1;
                return;
            end
        end
        if (ps.escape_pending) begin
            ps.escape_pending = 1'b0;
            if (ps.in_key)
                take_key(c);
            else if (ps.in_value)
                take_value(c);
            return;
        end
        if (c == CH_BACKSLASH) begin
            ps.escape_pending = 1'b1;
            return;
        end
        if (c == CH_QUOTE) begin
            ps.inside_string = !ps.inside_string;
            if (ps.inside_string) begin
                if (!ps.in_key && !ps.in_value) begin
                    ps.in_key = 1'b1;
                    ps.key_position = '0;
                    ps.key_compare_ok = 1'b1;
                end
            end
            else if (ps.in_key) begin
                ps.in_key = 1'b0;
                if (ps.key_compare_ok && ps.key_position == key_len)
                    ps.key_matched = 1'b1;
            end
            else if (ps.in_value) begin
                ps.in_value = 1'b0;
                if (ps.key_matched)
                    finish_search();
            end
            return;
        end
        if (ps.inside_string) begin
            if (ps.in_key)
                take_key(c);
            else if (ps.in_value)
                take_value(c);
            return;
        end
        if (c == CH_COLON && ps.key_matched && !ps.in_value) begin
            ps.skipping_space = 1'b1;
            return;
        end
        if (ps.in_value) begin
            if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACKET) begin
                ps.in_value = 1'b0;
                if (ps.key_matched)
                    finish_search();
            end
            else begin
                take_value(c);
            end
        end
    endfunction

    function void predict_beat(input logic [7:0] c, input logic first, input logic last);
        beat = '0;
        if (first)
            ps = PARSER_CLEAR;
        if (!ps.search_finished) begin
            scan_byte(c);
            if (!ps.search_finished && last)
                finish_search();
        end
        if (beat.value_valid || beat.done_res) begin
            beat.present = 1'b1;
            beat.found = beat.done_res && beat.found;
            beat.value_length = ps.value_position;
            pending_values.push_back(beat);
        end
    endfunction

    function void flag_error(input string why, input step_result_t want);
        errors++;
        if (errors <= 10)
            $display({"%0t ns: %s: expected byte %02h valid %0b done %0b found %0b len %0d,",
                      " got byte %02h valid %0b done %0b found %0b len %0d"},
                     $realtime, why, want.value_byte, want.value_valid, want.done_res,
                     want.found, want.value_length, value_byte, value_valid, done_res,
                     found, value_length);
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        step_result_t want;
        if (!rst_n) begin
            ps = PARSER_CLEAR;
            for (int w = 0; w < KEY_WORDS; w++)
                key_word[w] = '0;
            key_len = '0;
            cap_reg = CAP_W'(VALUE_MAX_DEF);
            pending_values.delete();
            errors = 0;
            outstanding <= 0;
            mismatch_count <= 0;
        end
        else begin
            // results first: a result beat never belongs to a text beat taken at this edge
            if (result_valid && result_ready) begin
                if (pending_values.size() == 0) begin
                    want = '0;
                    flag_error("result beat with nothing expected", want);
                end
                else begin
                    want = pending_values.pop_front();
                    if (want.value_byte !== value_byte || want.value_valid !== value_valid ||
                        want.done_res !== done_res || want.found !== found ||
                        want.value_length !== value_length)
                        flag_error("result beat mismatch", want);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY_WORD_0: key_word[0] = cfg_data;
                    REG_KEY_WORD_1: key_word[1] = cfg_data;
                    REG_KEY_WORD_2: key_word[2] = cfg_data;
                    REG_KEY_WORD_3: key_word[3] = cfg_data;
                    REG_KEY_LENGTH: key_len = cfg_data[KEY_POS_W-1:0];
                    REG_VALUE_CAP:  cap_reg = cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            end
            if (text_valid && text_ready)
                predict_beat(text_byte, first_byte, last_byte);
            outstanding <= pending_values.size();
            mismatch_count <= errors;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the streaming JSON key/value extractor: short
// hand-written documents, then randomised documents and noise under a range
// of target keys and value capacities, with bursty sending and a stalling
// receiver. Prediction and comparison live in jkv_value_checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jkv_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 850;
    localparam int PHASE_ITEMS  = 130;

    // key word registers in index order
    localparam logic [CFG_INDEX_W-1:0] WORD_REGS [KEY_WORDS] =
        '{REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3};

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index    = '0;
    logic [KEY_WORD_W-1:0]   cfg_data     = '0;
    logic                    text_valid   = 1'b0;
    logic                    text_ready;
    logic [7:0]              text_byte    = '0;
    logic                    first_byte   = 1'b0;
    logic                    last_byte    = 1'b0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic [7:0]              value_byte;
    logic                    value_valid;
    logic                    done_res;
    logic                    found;
    logic [VAL_POS_W-1:0]    value_length;

    int                      mismatch_count;
    int                      outstanding;
    int                      cycle_count = 0;

    // sender bookkeeping
    int                      burst_left = 0;
    int                      items_sent = 0;

    // current target key as the document generator sees it
    logic [7:0]              wanted_key [KEY_BYTES_DEF];
    int                      target_len;

    // document under construction
    logic [7:0]              doc [$];

    json_key_value_extractor_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value_byte   (value_byte),
        .value_valid  (value_valid),
        .done_res     (done_res),
        .found        (found),
        .value_length (value_length)
    );

    jkv_value_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .text_valid     (text_valid),
        .text_ready     (text_ready),
        .text_byte      (text_byte),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .value_byte     (value_byte),
        .value_valid    (value_valid),
        .done_res       (done_res),
        .found          (found),
        .value_length   (value_length),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // 12 ns clock
    always #6 clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** json_key_value_extractor_top: FAILED **");
            $finish;
        end
    end

    // receiver: stall behaviour follows bits 9:7 of cycle_count, cycling through
    // always ready, coin toss, mostly stalled, periodic and mostly ready
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            result_ready <= 1'b0;
        else begin
            case (cycle_count[9:7])
                3'd0, 3'd5: result_ready <= 1'b1;
                3'd1:       result_ready <= ($urandom_range(0, 1) == 0);
                3'd2:       result_ready <= ($urandom_range(0, 3) == 0);
                3'd3:       result_ready <= (cycle_count[2:0] != 3'd0);
                default:    result_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // one text beat; bursts of random length separated by random gaps,
    // with the odd long burst so that stretches without idling occur too
    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 20);
        end
        burst_left--;
        text_valid <= 1'b1;
        text_byte  <= b;
        first_byte <= f;
        last_byte  <= l;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // drop valid and hold off until every predicted result beat has drained;
    // the first edge lets the checker count the beat taken at this one, the
    // tail covers a beat that is still in flight but yields no result
    task automatic drain_results();
        text_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc.size(); i++)
            send_byte(doc[i], i == 0, i == doc.size() - 1);
    endtask

    // write all six registers from the current target and a capacity
    task automatic load_setting(input int cap_value);
        logic [KEY_WORD_W-1:0] word;
        for (int w = 0; w < KEY_WORDS; w++) begin
            // bytes past the key length are garbage on purpose
            word = {$urandom, $urandom};
            for (int b = 0; b < 8; b++)
                if (w * 8 + b < target_len)
                    word[b*8 +: 8] = wanted_key[w*8 + b];
            cfg_we    <= 1'b1;
            cfg_index <= WORD_REGS[w];
            cfg_data  <= word;
            @(posedge clk);
        end
        // upper bits of the narrow registers carry noise
        word = {$urandom, $urandom};
        word[KEY_POS_W-1:0] = target_len[KEY_POS_W-1:0];
        cfg_index <= REG_KEY_LENGTH;
        cfg_data  <= word;
        @(posedge clk);
        word = {$urandom, $urandom};
        word[CAP_W-1:0] = cap_value[CAP_W-1:0];
        cfg_index <= REG_VALUE_CAP;
        cfg_data  <= word;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // target bytes: mostly lower-case letters so near misses are common,
    // now and then any byte value at all
    function automatic void pick_target(input int len);
        target_len = len;
        for (int i = 0; i < KEY_BYTES_DEF; i++)
            wanted_key[i] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                        : rand_letter();
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            doc.push_back(s[i]);
    endfunction

    function automatic void add_blanks(input int most);
        int n;
        n = $urandom_range(0, most);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0:       doc.push_back(CH_SPACE);
                1:       doc.push_back(CH_CR);
                default: doc.push_back(CH_LF);
            endcase
        end
    endfunction

    // quoted key: exact target, target with a tail, truncated target,
    // target with one byte changed, or an unrelated word
    function automatic void add_key();
        logic [7:0] kb [$];
        int         pick;
        int         n;
        pick = $urandom_range(0, 9);
        if (pick < 4 || pick == 7 || pick == 8) begin
            for (int i = 0; i < target_len; i++)
                kb.push_back(wanted_key[i]);
            if (pick == 7)
                repeat ($urandom_range(1, 3)) kb.push_back(rand_letter());
            if (pick == 8 && kb.size() > 0)
                kb[$urandom_range(0, kb.size() - 1)] ^= 8'($urandom_range(1, 255));
        end
        else if (pick == 4 && target_len > 0) begin
            for (int i = 0; i < target_len - 1; i++)
                kb.push_back(wanted_key[i]);
        end
        else begin
            n = $urandom_range(0, 6);
            repeat (n) kb.push_back(rand_letter());
        end
        doc.push_back(CH_QUOTE);
        foreach (kb[i]) begin
            // quote and backslash must be escaped, other bytes sometimes are
            if (kb[i] == CH_QUOTE || kb[i] == CH_BACKSLASH || $urandom_range(0, 9) == 0)
                doc.push_back(CH_BACKSLASH);
            doc.push_back(kb[i]);
        end
        doc.push_back(CH_QUOTE);
    endfunction

    // quoted strings (occasionally long enough to hit any capacity),
    // bare tokens with embedded spaces, arrays and nested objects
    function automatic void add_value();
        int n;
        case ($urandom_range(0, 5))
            0, 1: begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 300)
                                                  : $urandom_range(0, 12);
                doc.push_back(CH_QUOTE);
                repeat (n) begin
                    case ($urandom_range(0, 11))
                        0: begin
                            doc.push_back(CH_BACKSLASH);
                            case ($urandom_range(0, 2))
                                0:       doc.push_back(CH_QUOTE);
                                1:       doc.push_back(CH_BACKSLASH);
                                default: doc.push_back(8'($urandom_range(0, 255)));
                            endcase
                        end
                        1:       doc.push_back(CH_SPACE);
                        2:       doc.push_back(8'h30 + 8'($urandom_range(0, 9)));
                        default: doc.push_back(rand_letter());
                    endcase
                end
                doc.push_back(CH_QUOTE);
            end
            2, 3: begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0:       doc.push_back(CH_SPACE);
                        1:       doc.push_back(rand_letter());
                        default: doc.push_back(8'h30 + 8'($urandom_range(0, 9)));
                    endcase
                end
            end
            4:       add_text("[1, 2]");
            default: add_text("{\"a\": 7}");
        endcase
    endfunction

    // a small object; one in eight is cut short to end mid-structure
    function automatic void build_doc();
        int members;
        doc.delete();
        doc.push_back(8'h7B);
        add_blanks(1);
        members = $urandom_range(1, 4);
        for (int m = 0; m < members; m++) begin
            add_key();
            add_blanks(1);
            // now and then a key with no colon at all
            if ($urandom_range(0, 11) != 0)
                doc.push_back(CH_COLON);
            add_blanks(3);
            add_value();
            if (m != members - 1)
                doc.push_back(CH_COMMA);
            add_blanks(1);
        end
        doc.push_back(CH_RBRACE);
        if ($urandom_range(0, 7) == 0)
            doc = doc[0:$urandom_range(0, doc.size() - 1)];
    endfunction

    // random bytes with stray document boundaries
    task automatic send_noise();
        int n;
        n = $urandom_range(5, 30);
        repeat (n)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                      $urandom_range(0, 15) == 0);
    endtask

    initial begin
        int phase;
        int cap_value;
        int phase_end;

        // reset held from the start, released once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part: key "k", capacity 4 ----------------
        target_len = 1;
        wanted_key[0] = 8'h6B;
        load_setting(4);

        // quoted value with an escaped quote; done and found on the closing
        // quote, the trailing brace and its last flag fall after the finish
        doc.delete();
        add_text("{\"k\":\"a\\\"b\"}");
        send_doc();

        // bare value after a blank: the newline is captured, the fourth byte
        // overflows the capacity and the closing bracket ends the search
        doc.delete();
        add_text("\"k\": x\nyz]");
        send_doc();

        // document ends inside a key that is not the target: done, not found;
        // a following byte with no first flag is ignored
        doc.delete();
        add_text("{\"q");
        doc.push_back(8'hFF);
        send_doc();
        send_byte(8'h00, 1'b0, 1'b0);

        // ---------------- random part ----------------
        drain_results();
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            // extremes first, then free choice of key and capacity
            case (phase)
                0: begin
                    pick_target(KEY_BYTES_DEF - 1);
                    cap_value = VALUE_MAX_DEF;
                end
                1: begin
                    pick_target(0);
                    cap_value = 0;
                end
                2: begin
                    pick_target($urandom_range(2, 6));
                    wanted_key[$urandom_range(0, target_len - 1)] = 8'h00;
                    cap_value = $urandom_range(VALUE_MAX_DEF + 1, 511);
                end
                3: begin
                    pick_target(1);
                    cap_value = 1;
                end
                default: begin
                    pick_target(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(1, 6));
                    case ($urandom_range(0, 5))
                        0:       cap_value = 0;
                        1:       cap_value = 1;
                        2:       cap_value = $urandom_range(2, 8);
                        3:       cap_value = $urandom_range(9, VALUE_MAX_DEF);
                        4:       cap_value = VALUE_MAX_DEF;
                        default: cap_value = $urandom_range(VALUE_MAX_DEF + 1, 511);
                    endcase
                end
            endcase
            load_setting(cap_value);

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < RANDOM_ITEMS) begin
                if ($urandom_range(0, 7) == 0)
                    send_noise();
                else begin
                    build_doc();
                    send_doc();
                end
                // sometimes the sender waits for the result side to empty
                if ($urandom_range(0, 9) == 0)
                    drain_results();
            end
            // registers only change with nothing in flight
            drain_results();
            phase++;
        end

        // ---------------- verdict ----------------
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("** json_key_value_extractor_top: PASSED **");
        else
            $display("** json_key_value_extractor_top: FAILED **");
        $finish;
    end

endmodule
